// ----- design/sksum_pkg.sv -----
package sksum_pkg;

  // Field widths
  localparam int unsigned ModeW    = 2;
  localparam int unsigned SpoolW   = 32;
  localparam int unsigned DiaInW   = 16;
  localparam int unsigned WeightW  = 32;
  localparam int unsigned WtypeW   = 2;
  localparam int unsigned RidxW    = 5;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned CountW   = 6;
  localparam int unsigned SlotW    = 5;
  localparam int unsigned KeyW     = 9;
  localparam int unsigned SumW     = 32;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 6;
  localparam int unsigned PosW     = 8;

  // Beat layout
  localparam int unsigned InDataW  = 96;
  localparam int unsigned OutDataW = 56;

  localparam int unsigned TableDepthDef = 32;
  localparam logic [DiaInW-1:0] MaxDiameter = 16'd500;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegRequiredType = 1'd0;
  localparam logic [CfgIdxW-1:0] RegCapacity     = 1'd1;

  // Item kinds
  localparam logic [ModeW-1:0] ModeStart  = 2'd0;
  localparam logic [ModeW-1:0] ModeRecord = 2'd1;
  localparam logic [ModeW-1:0] ModeRead   = 2'd2;
  localparam logic [ModeW-1:0] ModeNone   = 2'd3;

  // Result status
  localparam logic [StatusW-1:0] StAdded   = 3'd0;
  localparam logic [StatusW-1:0] StMerged  = 3'd1;
  localparam logic [StatusW-1:0] StSkipped = 3'd2;
  localparam logic [StatusW-1:0] StFailed  = 3'd3;
  localparam logic [StatusW-1:0] StAlready = 3'd4;
  localparam logic [StatusW-1:0] StDone    = 3'd5;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_ADD
  } cell_op_e;

  typedef struct packed {
    cell_op_e             op;
    logic [PosW-1:0]      pos;
    logic [KeyW-1:0]      key;
    logic [SumW-1:0]      val;
  } cell_cmd_t;

  typedef struct packed {
    logic lt;
    logic eq;
    logic ovf;
  } cell_flags_t;

endpackage

// ----- design/sorted_key_sum_table_core.sv -----
// Sorted diameter table: keeps up to TableDepth distinct wire diameters in
// ascending order, each with a summed active weight, built from parsed spool
// records. tuser on the input selects the beat kind (start, record, read;
// kind three is dropped with no result). Every accepted beat other than kind
// three yields exactly one result beat. The table is a row of cells: each
// cell compares its own key with the incoming diameter as the beat is taken,
// a decode step turns those flags into an insert slot or a merge hit, the
// cells then shift up by one neighbor or add in place, and a final step
// reads the touched slot into the output register. Ready comes back in the
// same cycle the result beat turns valid, so the block takes no new item
// until it is through with the last, passing through the compare, decode,
// update and readout sequence; a kind three beat lets the next beat in right
// after its decode step. The readout step waits while the output register
// holds a beat not yet taken, with ready low. The store has no reset:
// only slots below the entry count are ever shown. A failed check, a full
// table or a 32-bit sum overflow empties the table and makes every further
// record answer "already failed" until the next start beat. Configuration
// writes must only happen while the block is idle.
module sorted_key_sum_table_core #(
  parameter int unsigned TableDepth = sksum_pkg::TableDepthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // config write port
  input  logic                              cfg_we_i,
  input  logic [sksum_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [sksum_pkg::CfgDataW-1:0]    cfg_wdata_i,
  // input beats
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // spool[31:0], diameter[47:32], weight[79:48], is_active[80],
  // has_type[81], material[83:82], well_formed[84], read_index[89:85]
  input  logic [sksum_pkg::InDataW-1:0]     s_axis_tdata,
  // mode[1:0]
  input  logic [sksum_pkg::ModeW-1:0]       s_axis_tuser,
  // result beats
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // entry_count[5:0], entry_slot[10:6], entry_diameter[19:11],
  // entry_grams[51:20]
  output logic [sksum_pkg::OutDataW-1:0]    m_axis_tdata,
  // status[2:0]
  output logic [sksum_pkg::StatusW-1:0]     m_axis_tuser
);
  import sksum_pkg::*;

  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW = $clog2(TableDepth + 1);
  localparam int unsigned CmpW = (CntW > CountW) ? CntW : CountW;
  localparam int unsigned RdW  = (CntW > RidxW) ? CntW : RidxW;

  // sequencer codes
  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SDec  = 2'd1;
  localparam logic [1:0] SUpd  = 2'd2;
  localparam logic [1:0] SOut  = 2'd3;

  logic [1:0] state_q, state_d;

  // unpacked input beat
  logic [SpoolW-1:0]  in_spool;
  logic [DiaInW-1:0]  in_dia;
  logic [WeightW-1:0] in_wt;
  assign in_spool = s_axis_tdata[31:0];
  assign in_dia   = s_axis_tdata[47:32];
  assign in_wt    = s_axis_tdata[79:48];

  // latched beat
  logic [ModeW-1:0]   mode_q;
  logic [SpoolW-1:0]  spool_q;
  logic [DiaInW-1:0]  dia_q;
  logic [WeightW-1:0] wt_q;
  logic               act_q, htype_q, formed_q;
  logic [WtypeW-1:0]  wtype_q;
  logic [RidxW-1:0]   ridx_q;

  // table control and config
  logic [CntW-1:0]     used_q, used_d;
  logic [SpoolW-1:0]   last_q, last_d;
  logic                failed_q, failed_d;
  logic                req_type_q;
  logic [CfgDataW-1:0] cap_q;

  // decision registers
  logic [StatusW-1:0] status_q, status_d;
  cell_cmd_t          cmd_q, cmd_d, cell_cmd;
  logic               show_q, show_d;
  logic [IdxW-1:0]    sel_q, sel_d;
  logic [SlotW-1:0]   slot_q, slot_d;

  // output register
  logic                m_valid_q, m_valid_d;
  logic [OutDataW-1:0] m_data_q, m_data_d;
  logic [StatusW-1:0]  m_user_q, m_user_d;

  logic accept;
  assign s_axis_tready = (state_q == SIdle);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // cell row
  logic [KeyW-1:0]    key_a    [TableDepth];
  logic [SumW-1:0]    sum_a    [TableDepth];
  logic [KeyW-1:0]    prev_key [TableDepth];
  logic [SumW-1:0]    prev_sum [TableDepth];
  cell_flags_t        flags_a  [TableDepth];
  logic [TableDepth-1:0] lt_v, eq_v, ovf_v, in_use;

  assign cell_cmd = (state_q == SUpd) ? cmd_q : cell_cmd_t'{op: CELL_HOLD, default: '0};

  for (genvar i = 0; i < TableDepth; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_key[i] = '0;
      assign prev_sum[i] = '0;
    end else begin : g_link
      assign prev_key[i] = key_a[i-1];
      assign prev_sum[i] = sum_a[i-1];
    end

    assign in_use[i] = (CntW'(i) < used_q);
    assign lt_v[i]   = flags_a[i].lt;
    assign eq_v[i]   = flags_a[i].eq;
    assign ovf_v[i]  = flags_a[i].ovf;

    sksum_cell #(
      .Idx (i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmp_en_i   (accept),
      .cmp_key_i  (in_dia[KeyW-1:0]),
      .cmp_wt_i   (in_wt),
      .in_use_i   (in_use[i]),
      .cmd_i      (cell_cmd),
      .prev_key_i (prev_key[i]),
      .prev_sum_i (prev_sum[i]),
      .key_o      (key_a[i]),
      .sum_o      (sum_a[i]),
      .flags_o    (flags_a[i])
    );
  end

  // Sorted keys give a thermometer of lt flags; the insert slot sits just
  // past its top edge.
  logic [TableDepth-1:0] edge_v;
  logic [CntW-1:0]       pos_c;
  logic                  found, ovf_hit, bad, full, rd_hit;
  logic [CmpW-1:0]       cap_eff;

  assign edge_v  = lt_v & ~(lt_v >> 1);
  assign found   = |eq_v;
  assign ovf_hit = |(eq_v & ovf_v);

  always_comb begin
    pos_c = '0;
    for (int unsigned i = 0; i < TableDepth; i++) begin
      pos_c = pos_c | (edge_v[i] ? CntW'(i + 1) : '0);
    end
  end

  assign cap_eff = (CmpW'(cap_q) > CmpW'(TableDepth)) ? CmpW'(TableDepth) : CmpW'(cap_q);
  assign full    = (CmpW'(used_q) >= cap_eff);
  assign rd_hit  = (RdW'(ridx_q) < RdW'(used_q));

  assign bad = !formed_q || (spool_q == '0) || (spool_q <= last_q) ||
               (dia_q == '0) || (dia_q > MaxDiameter) ||
               (htype_q && (wtype_q > 2'd1));

  // decode
  always_comb begin
    state_d  = state_q;
    used_d   = used_q;
    last_d   = last_q;
    failed_d = failed_q;
    status_d = status_q;
    cmd_d    = cmd_q;
    show_d   = show_q;
    sel_d    = sel_q;
    slot_d   = slot_q;

    unique case (state_q)
      SIdle: begin
        if (accept) begin
          state_d = SDec;
        end
      end
      SDec: begin
        state_d   = SUpd;
        cmd_d     = '{op: CELL_HOLD, default: '0};
        cmd_d.pos = PosW'(pos_c);
        cmd_d.key = dia_q[KeyW-1:0];
        cmd_d.val = act_q ? wt_q : '0;
        show_d    = 1'b0;
        sel_d     = pos_c[IdxW-1:0];
        slot_d    = '0;
        unique case (mode_q)
          ModeStart: begin
            used_d   = '0;
            last_d   = '0;
            failed_d = 1'b0;
            status_d = StDone;
          end
          ModeRead: begin
            status_d = StDone;
            slot_d   = ridx_q;
            sel_d    = IdxW'(ridx_q);
            show_d   = rd_hit;
          end
          ModeRecord: begin
            if (failed_q) begin
              status_d = StAlready;
            end else if (bad) begin
              used_d   = '0;
              failed_d = 1'b1;
              status_d = StFailed;
            end else begin
              last_d = spool_q;
              if (!htype_q || (wtype_q != {1'b0, req_type_q})) begin
                status_d = StSkipped;
              end else if (!found) begin
                if (full) begin
                  used_d   = '0;
                  failed_d = 1'b1;
                  status_d = StFailed;
                end else begin
                  cmd_d.op = CELL_INS;
                  used_d   = used_q + 1'b1;
                  status_d = StAdded;
                  show_d   = 1'b1;
                  slot_d   = SlotW'(pos_c);
                end
              end else if (act_q && ovf_hit) begin
                used_d   = '0;
                failed_d = 1'b1;
                status_d = StFailed;
              end else begin
                cmd_d.op = act_q ? CELL_ADD : CELL_HOLD;
                status_d = StMerged;
                show_d   = 1'b1;
                slot_d   = SlotW'(pos_c);
              end
            end
          end
          default: begin
            // unused kind: no result
            state_d = SIdle;
          end
        endcase
      end
      SUpd: begin
        state_d = SOut;
      end
      default: begin
        if (!m_valid_q || m_axis_tready) begin
          state_d = SIdle;
        end
      end
    endcase
  end

  // output register, loaded once the previous beat is gone
  always_comb begin
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    if ((state_q == SOut) && (!m_valid_q || m_axis_tready)) begin
      m_valid_d = 1'b1;
      m_user_d  = status_q;
      m_data_d  = {4'b0,
                   show_q ? sum_a[sel_q] : '0,
                   show_q ? key_a[sel_q] : '0,
                   slot_q,
                   CountW'(used_q)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SIdle;
      used_q     <= '0;
      last_q     <= '0;
      failed_q   <= 1'b0;
      req_type_q <= 1'b0;
      cap_q      <= CfgDataW'(32);
      m_valid_q  <= 1'b0;
      cmd_q      <= '{op: CELL_HOLD, default: '0};
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      last_q    <= last_d;
      failed_q  <= failed_d;
      m_valid_q <= m_valid_d;
      cmd_q     <= cmd_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegRequiredType: req_type_q <= cfg_wdata_i[0];
          default:         cap_q      <= cfg_wdata_i;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q   <= s_axis_tuser;
      spool_q  <= in_spool;
      dia_q    <= in_dia;
      wt_q     <= in_wt;
      act_q    <= s_axis_tdata[80];
      htype_q  <= s_axis_tdata[81];
      wtype_q  <= s_axis_tdata[83:82];
      formed_q <= s_axis_tdata[84];
      ridx_q   <= s_axis_tdata[89:85];
    end
    status_q <= status_d;
    show_q   <= show_d;
    sel_q    <= sel_d;
    slot_q   <= slot_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

// ----- design/sksum_cell.sv -----
module sksum_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmp_en_i,
  input  logic [sksum_pkg::KeyW-1:0]    cmp_key_i,
  input  logic [sksum_pkg::SumW-1:0]    cmp_wt_i,
  input  logic                          in_use_i,
  input  sksum_pkg::cell_cmd_t          cmd_i,
  input  logic [sksum_pkg::KeyW-1:0]    prev_key_i,
  input  logic [sksum_pkg::SumW-1:0]    prev_sum_i,
  output logic [sksum_pkg::KeyW-1:0]    key_o,
  output logic [sksum_pkg::SumW-1:0]    sum_o,
  output sksum_pkg::cell_flags_t        flags_o
);
  import sksum_pkg::*;

  logic [KeyW-1:0] key_q, key_d;
  logic [SumW-1:0] sum_q, sum_d;
  cell_flags_t     flags_q, flags_d;
  logic [SumW:0]   wide_sum;
  logic            here;

  assign wide_sum = {1'b0, sum_q} + {1'b0, cmp_wt_i};
  assign here     = (cmd_i.pos == PosW'(Idx));

  always_comb begin
    flags_d = flags_q;
    if (cmp_en_i) begin
      flags_d.lt  = in_use_i && (key_q < cmp_key_i);
      flags_d.eq  = in_use_i && (key_q == cmp_key_i);
      flags_d.ovf = wide_sum[SumW];
    end
  end

  // insert shifts everything at and above the slot up by one
  always_comb begin
    key_d = key_q;
    sum_d = sum_q;
    unique case (cmd_i.op)
      CELL_INS: begin
        if (cmd_i.pos < PosW'(Idx)) begin
          key_d = prev_key_i;
          sum_d = prev_sum_i;
        end else if (here) begin
          key_d = cmd_i.key;
          sum_d = cmd_i.val;
        end
      end
      CELL_ADD: begin
        if (here) begin
          sum_d = sum_q + cmd_i.val;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    sum_q <= sum_d;
  end

  assign key_o   = key_q;
  assign sum_o   = sum_q;
  assign flags_o = flags_q;

endmodule

// ----- design/sksum_chk.sv -----
module sksum_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [sksum_pkg::OutDataW-1:0]    m_axis_tdata,
  input logic [sksum_pkg::StatusW-1:0]     m_axis_tuser
);
  import sksum_pkg::*;

  // stalled result beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // one item in flight: ready drops after each accepted beat
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second beat taken while busy");

  // no entry shown for skipped or failed records
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == StSkipped || m_axis_tuser == StFailed ||
                      m_axis_tuser == StAlready) |-> m_axis_tdata[55:6] == '0)
    else $error("entry fields not cleared");

  // a fresh failure empties the table
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == StFailed) |-> m_axis_tdata[5:0] == '0)
    else $error("count not zero after failure");

endmodule

bind sorted_key_sum_table_core sksum_chk u_sksum_chk (.*);
